// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// ASSERT_ALWAYS checks that a property holds on every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/mpts_pkg.sv =====
package mpts_pkg;

    localparam int CHANNELS   = 28;
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MASK_W     = 28;
    localparam int CMD_W      = 2;
    localparam int CH_W       = 5;
    localparam int MODE_W     = 2;
    localparam int TIME_W     = 24;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_MODE   = 2'd1,
        CMD_TIMING = 2'd2
    } t_cmd_code;

    typedef enum logic [MODE_W-1:0] {
        MODE_INPUT  = 2'd0,
        MODE_OUTPUT = 2'd1,
        MODE_PWM    = 2'd2
    } t_mode;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 24'd2000;
    localparam logic [TIME_W-1:0] WIDTH_RESET  = 24'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_POST
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_is_tick;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== src/mpts_ctrl.sv =====
module mpts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  mpts_pkg::t_dp_stat i_stat,
    output mpts_pkg::t_dp_cmd  o_cmd
);

    mpts_pkg::t_state r_state, n_state;
    logic             r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mpts_pkg::ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        case (r_state)
            mpts_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_stat.in_is_tick ? mpts_pkg::ST_SCAN : mpts_pkg::ST_EXEC;
                end
            end
            mpts_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = mpts_pkg::ST_POST;
            end
            mpts_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = mpts_pkg::ST_POST;
                end
            end
            mpts_pkg::ST_POST: begin
                // wait for the output register to be free
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mpts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mpts_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;

endmodule

// ===== src/mpts_dp.sv =====
module mpts_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpts_pkg::t_dp_cmd             i_cmd,
    output mpts_pkg::t_dp_stat            o_stat,
    input  logic [mpts_pkg::CMD_W-1:0]    i_command,
    input  logic [mpts_pkg::CH_W-1:0]     i_channel,
    input  logic [mpts_pkg::MODE_W-1:0]   i_mode_value,
    input  logic [mpts_pkg::TIME_W-1:0]   i_period_ticks,
    input  logic [mpts_pkg::TIME_W-1:0]   i_width_ticks,
    output logic [mpts_pkg::MASK_W-1:0]   o_set_mask,
    output logic [mpts_pkg::MASK_W-1:0]   o_clr_mask,
    output logic                          o_accepted
);

    // latched command
    logic [mpts_pkg::CMD_W-1:0]  r_cmd;
    logic [mpts_pkg::CH_W-1:0]   r_ch;
    logic [mpts_pkg::MODE_W-1:0] r_mv;
    logic [mpts_pkg::TIME_W-1:0] r_per;
    logic [mpts_pkg::TIME_W-1:0] r_wid;

    logic [mpts_pkg::IDX_W-1:0]  r_idx;
    logic [mpts_pkg::CNT_W-1:0]  r_tick;
    logic [mpts_pkg::MASK_W-1:0] r_set;
    logic [mpts_pkg::MASK_W-1:0] r_clr;
    logic                        r_acc;

    // per-channel state
    logic [mpts_pkg::MODE_W-1:0] r_mode   [mpts_pkg::CHANNELS];
    logic [mpts_pkg::TIME_W-1:0] r_period [mpts_pkg::CHANNELS];
    logic [mpts_pkg::TIME_W-1:0] r_width  [mpts_pkg::CHANNELS];
    logic [mpts_pkg::CNT_W-1:0]  r_next   [mpts_pkg::CHANNELS];
    logic [mpts_pkg::CNT_W-1:0]  r_end    [mpts_pkg::CHANNELS];
    logic                        r_run    [mpts_pkg::CHANNELS];

    logic [mpts_pkg::MASK_W-1:0] r_out_set;
    logic [mpts_pkg::MASK_W-1:0] r_out_clr;
    logic                        r_out_acc;

    // scan of the channel at r_idx
    logic [mpts_pkg::MODE_W-1:0] mode_c;
    logic [mpts_pkg::TIME_W-1:0] per_c, wid_c;
    logic [mpts_pkg::CNT_W-1:0]  ns_c, pe_c, start_nx, end_nx;
    logic                        run_c, is_pwm, do_start, do_clr_end, do_stop;
    logic                        set_hit, clr_hit, scan_last;
    logic [mpts_pkg::MASK_W-1:0] idx_bit;

    logic ch_ok, mode_ok, timing_ok, exec_ok;
    logic wr_mode, wr_timing;

    assign mode_c = r_mode[r_idx];
    assign per_c  = r_period[r_idx];
    assign wid_c  = r_width[r_idx];
    assign ns_c   = r_next[r_idx];
    assign pe_c   = r_end[r_idx];
    assign run_c  = r_run[r_idx];

    assign is_pwm     = (mode_c == mpts_pkg::MODE_PWM);
    assign start_nx   = r_tick + mpts_pkg::CNT_W'(per_c);
    assign end_nx     = r_tick + mpts_pkg::CNT_W'(wid_c);
    assign do_start   = is_pwm && ((r_tick == ns_c) || !run_c);
    assign do_clr_end = !do_start && (r_tick == pe_c) && run_c && (pe_c != ns_c);
    assign do_stop    = !do_start && !do_clr_end && !is_pwm && (r_tick == ns_c) && run_c;
    // zero high time: start gives a clear instead of a set
    assign set_hit    = do_start && (wid_c != '0);
    assign clr_hit    = (do_start && (wid_c == '0)) || do_clr_end;
    assign scan_last  = (r_idx == mpts_pkg::IDX_W'(mpts_pkg::CHANNELS - 1));

    always_comb begin
        for (int k = 0; k < mpts_pkg::MASK_W; k++) begin
            idx_bit[k] = (mpts_pkg::CNT_W'(r_idx) == mpts_pkg::CNT_W'(k));
        end
    end

    assign ch_ok     = ({1'b0, r_ch} < (mpts_pkg::CH_W + 1)'(mpts_pkg::CHANNELS));
    assign mode_ok   = (r_mv <= mpts_pkg::MODE_PWM);
    assign timing_ok = (r_per != '0) && (r_wid <= r_per);
    assign wr_mode   = i_cmd.exec && (r_cmd == mpts_pkg::CMD_MODE) && ch_ok && mode_ok;
    assign wr_timing = i_cmd.exec && (r_cmd == mpts_pkg::CMD_TIMING) && ch_ok && timing_ok;
    assign exec_ok   = wr_mode || wr_timing;

    assign o_stat.in_is_tick = (i_command == mpts_pkg::CMD_TICK);
    assign o_stat.scan_last  = scan_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_command;
            r_ch  <= i_channel;
            r_mv  <= i_mode_value;
            r_per <= i_period_ticks;
            r_wid <= i_width_ticks;
        end
        if (i_cmd.out_load) begin
            r_out_set <= r_set;
            r_out_clr <= r_clr;
            r_out_acc <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_tick <= '0;
            r_set  <= '0;
            r_clr  <= '0;
            r_acc  <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_idx <= '0;
            r_set <= '0;
            r_clr <= '0;
            r_acc <= 1'b0;
        end else if (i_cmd.exec) begin
            r_acc <= exec_ok;
        end else if (i_cmd.scan) begin
            r_set <= r_set | (set_hit ? idx_bit : '0);
            r_clr <= r_clr | (clr_hit ? idx_bit : '0);
            if (scan_last) begin
                r_tick <= r_tick + 1'b1;
                r_acc  <= 1'b1;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < mpts_pkg::CHANNELS; c++) begin
            if (!i_rst_n) begin
                r_mode[c]   <= mpts_pkg::MODE_OUTPUT;
                r_period[c] <= mpts_pkg::PERIOD_RESET;
                r_width[c]  <= mpts_pkg::WIDTH_RESET;
                r_next[c]   <= '0;
                r_end[c]    <= '0;
                r_run[c]    <= 1'b0;
            end else begin
                if (wr_mode && (r_ch == mpts_pkg::CH_W'(c))) begin
                    r_mode[c] <= r_mv;
                end
                if (wr_timing && (r_ch == mpts_pkg::CH_W'(c))) begin
                    r_period[c] <= r_per;
                    r_width[c]  <= r_wid;
                end
                if (i_cmd.scan && (r_idx == mpts_pkg::IDX_W'(c))) begin
                    if (do_start) begin
                        r_run[c]  <= 1'b1;
                        r_next[c] <= start_nx;
                        r_end[c]  <= end_nx;
                    end else if (do_stop) begin
                        r_run[c] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_set_mask = r_out_set;
    assign o_clr_mask = r_out_clr;
    assign o_accepted = r_out_acc;

endmodule

// ===== src/multichannel_pwm_tick_scheduler_unit.sv =====
// Multichannel PWM tick scheduler.
// Input stream (s_axis): one command per item. tuser carries the command code
// (tick, channel mode write, channel period/width write); tdata carries the
// channel number, new mode and new period/high time in ticks.
// Output stream (m_axis): exactly one result item per command, in order, with
// the set mask, clear mask and an accepted flag. Masks are zero except on ticks.
// A tick walks the channels one per cycle through a single shared compare/add
// slice (states IDLE, SCAN, POST); mode and timing writes pass IDLE, EXEC and
// POST. One item is in work at a time; the next is taken once the previous
// result has moved to the output register.
// Reset (i_rst_n low, synchronous) zeroes the tick counter, puts every channel
// in output mode with period 2000 and high time 100, not running, and empties
// the output register. If the receiver stalls, the result is held in the output
// register; the next command is still accepted and worked on, and its result
// waits in the datapath until the output register frees up.
`include "assert_macros.svh"

module multichannel_pwm_tick_scheduler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [4:0] channel, [6:5] mode_value, [30:7] period_ticks, [54:31] width_ticks
    input  logic [mpts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] command
    input  logic [mpts_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [27:0] set_mask, [55:28] clr_mask, [56] accepted, rest zero
    output logic [mpts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int MODE_LO = mpts_pkg::CH_W;
    localparam int PER_LO  = MODE_LO + mpts_pkg::MODE_W;
    localparam int WID_LO  = PER_LO + mpts_pkg::TIME_W;
    localparam int OUT_USED = 2 * mpts_pkg::MASK_W + 1;

    mpts_pkg::t_dp_cmd  dp_cmd;
    mpts_pkg::t_dp_stat dp_stat;

    logic [mpts_pkg::MASK_W-1:0] set_mask;
    logic [mpts_pkg::MASK_W-1:0] clr_mask;
    logic                        accepted;

    mpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mpts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command      (s_axis_tuser),
        .i_channel      (s_axis_tdata[mpts_pkg::CH_W-1:0]),
        .i_mode_value   (s_axis_tdata[PER_LO-1:MODE_LO]),
        .i_period_ticks (s_axis_tdata[WID_LO-1:PER_LO]),
        .i_width_ticks  (s_axis_tdata[WID_LO+mpts_pkg::TIME_W-1:WID_LO]),
        .o_set_mask     (set_mask),
        .o_clr_mask     (clr_mask),
        .o_accepted     (accepted)
    );

    assign m_axis_tdata = {{(mpts_pkg::OUT_DATA_W - OUT_USED){1'b0}},
                           accepted, clr_mask, set_mask};

    // While ready, the controller must not be driving a scan or a write.
    `ASSERT_NEVER(a_idle_no_work, i_clk, i_rst_n, s_axis_tready && (dp_cmd.scan || dp_cmd.exec))
    // Once an item is taken, no second one is taken on the next edge.
    `ASSERT_ALWAYS(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    // A channel gives either a set or a clear on one tick, never both.
    `ASSERT_NEVER(a_masks_disjoint, i_clk, i_rst_n, m_axis_tvalid && ((set_mask & clr_mask) != '0))
    // Non-zero masks only come from ticks, which are always accepted.
    `ASSERT_NEVER(a_masks_need_acc, i_clk, i_rst_n, m_axis_tvalid && !accepted && |(set_mask | clr_mask))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import mpts_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_PER_PH  = 442;
    localparam int LONG_HOLD      = 400;    // receiver hold-off, enough to back the block up
    localparam int SETTLE_CYCLES  = 40;     // a little over one tick scan
    localparam int QUIET_LIMIT    = 5000;   // cycles with no item moving on either side

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CH_W-1:0]   channel;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] width;
    } t_pwm_cmd;

    typedef struct {
        logic [MASK_W-1:0] set_mask;
        logic [MASK_W-1:0] clr_mask;
        logic              accepted;
    } t_pwm_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [4:0] channel, [6:5] mode_value, [30:7] period_ticks, [54:31] width_ticks
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] command
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [27:0] set_mask, [55:28] clr_mask, [56] accepted, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    multichannel_pwm_tick_scheduler_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scheduler model state, a private copy kept in step with the block
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  sched_now;
    logic [MODE_W-1:0] sched_mode   [CHANNELS];
    logic [TIME_W-1:0] sched_period [CHANNELS];
    logic [TIME_W-1:0] sched_width  [CHANNELS];
    logic [CNT_W-1:0]  sched_start  [CHANNELS];
    logic [CNT_W-1:0]  sched_end    [CHANNELS];
    logic              sched_run    [CHANNELS];

    t_pwm_cmd    pending_cmds [$];   // items still to be offered
    t_pwm_result results_due  [$];   // results owed by the block, oldest first
    t_pwm_cmd    cur_cmd;

    int err_count     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    bit hold_request  = 1'b0;
    bit hold_done     = 1'b0;

    // Applies one command to the model and returns the result it owes.
    // Start/end times wrap modulo 2^32 like the tick counter itself.
    function automatic t_pwm_result schedule_command(t_pwm_cmd it);
        t_pwm_result r;
        logic [CNT_W-1:0] now;
        bit pwm;
        int c;
        r = '{default: '0};
        case (it.cmd)
            CMD_TICK: begin
                now = sched_now;
                for (c = 0; c < CHANNELS; c++) begin
                    pwm = (sched_mode[c] == MODE_PWM);
                    if (pwm && (now == sched_start[c] || !sched_run[c])) begin
                        // new period; zero high time gives a clear instead of a set
                        sched_run[c]   = 1'b1;
                        sched_start[c] = now + CNT_W'(sched_period[c]);
                        sched_end[c]   = now + CNT_W'(sched_width[c]);
                        if (c < MASK_W) begin
                            if (sched_end[c] != now)
                                r.set_mask[c] = 1'b1;
                            else
                                r.clr_mask[c] = 1'b1;
                        end
                    end else if (now == sched_end[c] && sched_run[c] &&
                                 sched_end[c] != sched_start[c]) begin
                        // end of high time; full-width pulses never clear
                        if (c < MASK_W)
                            r.clr_mask[c] = 1'b1;
                    end else if (!pwm && now == sched_start[c] && sched_run[c]) begin
                        // left PWM mode: stop at the period boundary
                        sched_run[c] = 1'b0;
                    end
                end
                sched_now = now + 1;
                r.accepted = 1'b1;
            end
            CMD_MODE: begin
                if (it.channel < CHANNELS && it.mode <= MODE_PWM) begin
                    sched_mode[it.channel] = it.mode;
                    r.accepted = 1'b1;
                end
            end
            CMD_TIMING: begin
                if (it.channel < CHANNELS && it.period != '0 && it.width <= it.period) begin
                    sched_period[it.channel] = it.period;
                    sched_width[it.channel]  = it.width;
                    r.accepted = 1'b1;
                end
            end
            default: ;   // unused command code: rejected, no change
        endcase
        return r;
    endfunction

    function automatic t_pwm_cmd make_cmd(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                          logic [MODE_W-1:0] mode,
                                          logic [TIME_W-1:0] period,
                                          logic [TIME_W-1:0] width);
        t_pwm_cmd it;
        it.cmd     = cmd;
        it.channel = ch;
        it.mode    = mode;
        it.period  = period;
        it.width   = width;
        return it;
    endfunction

    // Mostly well-formed traffic: ticks, valid timing on real channels and
    // PWM enables, so channels cycle through many periods. The rest is
    // off-range channels, bad timing, mode 3 and the unused command code.
    // Fields a command ignores are left fully random.
    function automatic t_pwm_cmd random_command();
        t_pwm_cmd it;
        int pick;
        int sub;
        it.cmd     = CMD_W'($urandom);
        it.channel = CH_W'($urandom);
        it.mode    = MODE_W'($urandom);
        it.period  = TIME_W'($urandom);
        it.width   = TIME_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 55) begin
            it.cmd = CMD_TICK;
        end else if (pick < 75) begin
            it.cmd = CMD_TIMING;
            if ($urandom_range(9) != 0)
                it.channel = CH_W'($urandom_range(CHANNELS - 1));
            sub = $urandom_range(9);
            if (sub < 7)
                it.period = TIME_W'($urandom_range(1, 12));
            else if (sub < 9)
                it.period = TIME_W'($urandom_range(13, 300));
            sub = $urandom_range(9);
            case (sub)
                0: it.width = '0;
                1: it.width = it.period;
                2: if (it.period != TIME_MAX) it.width = it.period + 1'b1;
                3: ;   // leave fully random
                default: it.width = TIME_W'($urandom_range(it.period));
            endcase
        end else if (pick < 93) begin
            it.cmd = CMD_MODE;
            if ($urandom_range(9) != 0)
                it.channel = CH_W'($urandom_range(CHANNELS - 1));
            sub = $urandom_range(19);
            if (sub < 12)
                it.mode = MODE_PWM;
            else if (sub < 15)
                it.mode = MODE_INPUT;
            else if (sub < 18)
                it.mode = MODE_OUTPUT;
            else
                it.mode = MODE_BAD;
        end else if (pick < 97) begin
            it.cmd = CMD_UNUSED;
        end else begin
            it.cmd    = CMD_TIMING;
            it.period = '0;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued items, models the item on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(schedule_command(cur_cmd));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_axis_tdata  <= {1'b0, cur_cmd.width, cur_cmd.period,
                                      cur_cmd.mode, cur_cmd.channel};
                    s_axis_tuser  <= cur_cmd.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pwm_result exp_res;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result item with none owed: tdata=%h", m_axis_tdata);
                    err_count++;
                end else begin
                    exp_res = results_due.pop_front();
                    if (m_axis_tdata[MASK_W-1:0] !== exp_res.set_mask) begin
                        $error("set_mask: expected %h, got %h",
                               exp_res.set_mask, m_axis_tdata[MASK_W-1:0]);
                        err_count++;
                    end
                    if (m_axis_tdata[2*MASK_W-1:MASK_W] !== exp_res.clr_mask) begin
                        $error("clr_mask: expected %h, got %h",
                               exp_res.clr_mask, m_axis_tdata[2*MASK_W-1:MASK_W]);
                        err_count++;
                    end
                    if (m_axis_tdata[2*MASK_W] !== exp_res.accepted) begin
                        $error("accepted: expected %b, got %b",
                               exp_res.accepted, m_axis_tdata[2*MASK_W]);
                        err_count++;
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:2*MASK_W+1] !== '0) begin
                        $error("padding: expected 0, got %h",
                               m_axis_tdata[OUT_DATA_W-1:2*MASK_W+1]);
                        err_count++;
                    end
                end
            end
            // one long hold-off on request, counted here
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sender pause: holds until every owed result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() > 0 || s_axis_tvalid || results_due.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, bit with_hold);
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < RANDOM_PER_PH; n++)
            pending_cmds.push_back(random_command());
        if (with_hold)
            hold_request = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int c;
        sched_now = '0;
        for (c = 0; c < CHANNELS; c++) begin
            sched_mode[c]   = MODE_OUTPUT;
            sched_period[c] = PERIOD_RESET;
            sched_width[c]  = WIDTH_RESET;
            sched_start[c]  = '0;
            sched_end[c]    = '0;
            sched_run[c]    = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: all channels idle in output mode, then each corner in turn
        pending_cmds.push_back(make_cmd(CMD_TICK,   5'd0,  MODE_INPUT, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_TIMING, 5'd0,  MODE_INPUT, 24'd3, 24'd1));
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd0,  MODE_PWM,   '0, '0));
        // zero period, then width above period: both refused
        pending_cmds.push_back(make_cmd(CMD_TIMING, 5'd1,  MODE_INPUT, 24'd0, 24'd0));
        pending_cmds.push_back(make_cmd(CMD_TIMING, 5'd1,  MODE_INPUT, 24'd5, 24'd6));
        // full-width pulse: stays high, no clear
        pending_cmds.push_back(make_cmd(CMD_TIMING, 5'd2,  MODE_INPUT, 24'd4, 24'd4));
        // zero high time: clear at each start
        pending_cmds.push_back(make_cmd(CMD_TIMING, 5'd3,  MODE_INPUT, 24'd2, 24'd0));
        pending_cmds.push_back(make_cmd(CMD_TIMING, CH_W'(CHANNELS - 1), MODE_INPUT,
                                        TIME_MAX, TIME_MAX));
        // channel beyond the last, mode 3, unused command code
        pending_cmds.push_back(make_cmd(CMD_TIMING, CH_W'(CHANNELS), MODE_INPUT,
                                        24'd10, 24'd1));
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd31, MODE_PWM,   '0, '0));
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd5,  MODE_BAD,   '0, '0));
        pending_cmds.push_back(make_cmd(CMD_UNUSED, '1,    MODE_BAD,   '1, '1));
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd1,  MODE_PWM,   '0, '0));
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd2,  MODE_PWM,   '0, '0));
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd3,  MODE_PWM,   '0, '0));
        pending_cmds.push_back(make_cmd(CMD_MODE,   CH_W'(CHANNELS - 1), MODE_PWM, '0, '0));
        repeat (5) pending_cmds.push_back(make_cmd(CMD_TICK, '0, MODE_INPUT, '0, '0));
        // leaving PWM: channel 0 stops at its next start
        pending_cmds.push_back(make_cmd(CMD_MODE,   5'd0,  MODE_INPUT, '0, '0));
        repeat (3) pending_cmds.push_back(make_cmd(CMD_TICK, '0, MODE_INPUT, '0, '0));

        run_phase(30, 86, 1'b0);
        run_phase(86, 30, 1'b0);
        // no idling, opening with a long receiver hold-off to back the block up
        run_phase(0, 0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
